FILE: design/sxl_pkg.sv
package sxl_pkg;

	localparam int WORKERS_DEF = 16;
	localparam int QUEUE_SLOTS = 16;
	localparam logic [4:0] SHARED_MAX = 5'd31;

	localparam logic [1:0] MODE_LOCK_SH   = 2'd0;
	localparam logic [1:0] MODE_LOCK_EX   = 2'd1;
	localparam logic [1:0] MODE_UNLOCK_SH = 2'd2;
	localparam logic [1:0] MODE_UNLOCK_EX = 2'd3;

	localparam logic [2:0] KIND_GRANTED  = 3'd0;
	localparam logic [2:0] KIND_QUEUED   = 3'd1;
	localparam logic [2:0] KIND_RELEASED = 3'd2;
	localparam logic [2:0] KIND_WOKEN    = 3'd3;
	localparam logic [2:0] KIND_ERROR    = 3'd4;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] requester;
	} req_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] worker;
		logic       last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // request taken, evaluate it
		logic start;    // first response taken and a wakeup follows
		logic eval;     // queue entry read data is valid
		logic advance;  // woken response taken
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic wake;      // request started a wakeup
		logic woken;     // current entry is woken
		logic scan_end;  // current entry is the last one in the queue
	} sts_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RESP = 5'b00010,
		ST_RD   = 5'b00100,
		ST_EV   = 5'b01000,
		ST_WOUT = 5'b10000
	} state_t;

endpackage

FILE: design/shared_exclusive_latch_with_wait_queue_top.sv
// Lock requests and failed unlocks: one response, valid the cycle after accept.
// Unlock with wakeup: released response, then a scan of the wait queue through its RAM,
// which reads each entry, writes kept entries back and sends a woken response for each woken one.
// The next request is accepted only after the scan of the previous one has finished.
// Reset (arst_n low, asynchronous): latch free, queue empty, wake enabled.
module shared_exclusive_latch_with_wait_queue_top #(
	parameter int WORKERS = sxl_pkg::WORKERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sxl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sxl_pkg::rsp_t rsp
);
	import sxl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sxl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sxl_datapath #(.WORKERS(WORKERS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

FILE: design/sxl_ram.sv
module sxl_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/sxl_datapath.sv
module sxl_datapath #(
	parameter int WORKERS = sxl_pkg::WORKERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sxl_pkg::req_t req,
	input  sxl_pkg::cmd_t cmd,
	output sxl_pkg::sts_t sts,
	output sxl_pkg::rsp_t rsp
);
	import sxl_pkg::*;

	localparam int CAP = (WORKERS < QUEUE_SLOTS) ? WORKERS : QUEUE_SLOTS;
	localparam int QAW = $clog2(CAP);
	localparam logic [QAW:0] CAP_V = (QAW+1)'(CAP);
	localparam logic [QAW:0] ONE_V = (QAW+1)'(1);

	logic [4:0]   sh_q;
	logic         ex_q;
	logic         wen_q;
	logic [QAW:0] qlen_q, qsh_q, idx_q, keep_q, wcnt_q;
	logic         hx_q;
	logic         wake_q;
	rsp_t         rsp_q;

	logic         we;
	logic [QAW-1:0] waddr;
	logic [4:0]   wdata, rdata;

	sxl_ram #(.WIDTH(5), .DEPTH(CAP)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q[QAW-1:0]),
		.rdata (rdata)
	);

	// request evaluation
	logic       is_lock, is_ex, grant, full, unl_err, wake_new;
	logic [4:0] sh_nxt;
	always_comb begin
		is_lock = (req.mode == MODE_LOCK_SH) || (req.mode == MODE_LOCK_EX);
		is_ex   = (req.mode == MODE_LOCK_EX);
		grant   = is_ex ? (sh_q == 5'd0 && !ex_q) : (!ex_q && sh_q < SHARED_MAX);
		full    = (qlen_q >= CAP_V);
		unl_err = (req.mode == MODE_UNLOCK_EX) ? !ex_q : (sh_q == 5'd0);
		sh_nxt  = (req.mode == MODE_UNLOCK_SH) ? sh_q - 5'd1 : sh_q;
		wake_new = !is_lock && !unl_err && sh_nxt == 5'd0 && qlen_q != '0 && wen_q;
	end

	// scan evaluation
	logic i0, hx, woken, wlast, scan_end, fin;
	logic [QAW:0] keep_nxt;
	always_comb begin
		i0       = (idx_q == '0);
		hx       = i0 ? rdata[4] : hx_q;
		woken    = i0 || (!hx_q && !rdata[4]);
		wlast    = hx || (wcnt_q + ONE_V == qsh_q);
		scan_end = (idx_q + ONE_V == qlen_q);
		keep_nxt = keep_q + (QAW+1)'(cmd.eval && !woken);
		fin      = scan_end && ((cmd.eval && !woken) || cmd.advance);
	end

	always_comb begin
		we    = 1'b0;
		waddr = qlen_q[QAW-1:0];
		wdata = {is_ex, req.requester};
		if (cmd.accept) begin
			we = is_lock && !grant && !full;
		end else if (cmd.eval && !woken) begin
			we    = 1'b1;
			waddr = keep_q[QAW-1:0];
			wdata = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q   <= '0;
			ex_q   <= 1'b0;
			wen_q  <= 1'b1;
			qlen_q <= '0;
			qsh_q  <= '0;
			idx_q  <= '0;
			keep_q <= '0;
			wcnt_q <= '0;
			hx_q   <= 1'b0;
			wake_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				wake_q <= wake_new;
				if (is_lock) begin
					wen_q <= 1'b1;
					if (grant) begin
						if (is_ex) ex_q <= 1'b1;
						else sh_q <= sh_q + 5'd1;
					end else if (!full) begin
						qlen_q <= qlen_q + ONE_V;
						if (!is_ex) qsh_q <= qsh_q + ONE_V;
					end
				end else if (!unl_err) begin
					if (req.mode == MODE_UNLOCK_EX) ex_q <= 1'b0;
					sh_q <= sh_nxt;
					if (wake_new) wen_q <= 1'b0;
				end
			end
			if (cmd.start) begin
				idx_q  <= '0;
				keep_q <= '0;
				wcnt_q <= '0;
			end
			if (cmd.eval) begin
				if (i0) hx_q <= rdata[4];
				keep_q <= keep_nxt;
				if (woken) wcnt_q <= wcnt_q + ONE_V;
				else idx_q <= idx_q + ONE_V;
			end
			if (cmd.advance) begin
				idx_q <= idx_q + ONE_V;
			end
			if (fin) begin
				qlen_q <= keep_nxt;
				if (!hx_q) qsh_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rsp_q.worker <= req.requester;
			rsp_q.last   <= 1'b1;
			if (is_lock) begin
				rsp_q.kind <= grant ? KIND_GRANTED : (full ? KIND_ERROR : KIND_QUEUED);
			end else if (unl_err) begin
				rsp_q.kind <= KIND_ERROR;
			end else begin
				rsp_q.kind <= KIND_RELEASED;
				rsp_q.last <= !wake_new;
			end
		end else if (cmd.eval && woken) begin
			rsp_q.kind   <= KIND_WOKEN;
			rsp_q.worker <= rdata[3:0];
			rsp_q.last   <= wlast;
		end
	end

	assign rsp          = rsp_q;
	assign sts.wake     = wake_q;
	assign sts.woken    = woken;
	assign sts.scan_end = scan_end;

endmodule

FILE: design/sxl_ctrl.sv
module sxl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  sxl_pkg::sts_t sts,
	output sxl_pkg::cmd_t cmd
);
	import sxl_pkg::*;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!rsp_stall) begin
					cmd.start = sts.wake;
					state_nxt = sts.wake ? ST_RD : ST_IDLE;
				end
			end
			ST_RD: state_nxt = ST_EV;
			ST_EV: begin
				cmd.eval = 1'b1;
				if (sts.woken) state_nxt = ST_WOUT;
				else state_nxt = sts.scan_end ? ST_IDLE : ST_RD;
			end
			ST_WOUT: begin
				if (!rsp_stall) begin
					cmd.advance = 1'b1;
					state_nxt   = sts.scan_end ? ST_IDLE : ST_RD;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = (state_q == ST_RESP) || (state_q == ST_WOUT);

endmodule

FILE: design/sxl_checker.sv
module sxl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input sxl_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input sxl_pkg::rsp_t rsp
);
	import sxl_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("no response after accepted request");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!req_stall |-> !rsp_valid)
		else $error("response while ready for request");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == KIND_GRANTED || rsp.kind == KIND_QUEUED ||
		rsp.kind == KIND_ERROR) |-> rsp.last)
		else $error("single response without last");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.kind <= KIND_ERROR)
		else $error("bad response kind");

endmodule

bind shared_exclusive_latch_with_wait_queue_top sxl_checker u_sxl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
